### hw/rtl/ept_pkg.sv
package ept_pkg;

  typedef enum logic [1:0] {
    REQ_REF     = 2'd0,
    REQ_RX      = 2'd1,
    REQ_WEND    = 2'd2,
    REQ_RESTART = 2'd3
  } ept_req_e;

  typedef enum logic [2:0] {
    CFG_PERIOD      = 3'd0,
    CFG_MIN_SPACING = 3'd1,
    CFG_MIN_PERIOD  = 3'd2,
    CFG_MAX_PERIOD  = 3'd3,
    CFG_OFFSET      = 3'd4,
    CFG_ALPHA       = 3'd5,
    CFG_AVG_SAMPLES = 3'd6,
    CFG_MIN_VALID   = 3'd7
  } ept_cfg_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_REF,
    OP_RESTART,
    OP_DIFF,
    OP_QUAL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_ANGLE,
    OP_ROT_EDGE,
    OP_ROT_CUR,
    OP_VEC_WIN,
    OP_VEC_SEED,
    OP_CSTEP,
    OP_ACC_EDGE,
    OP_CUR,
    OP_SEED_ACC,
    OP_SEED_FIN,
    OP_EMA,
    OP_WIN_END
  } ept_op_e;

  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned IterBits    = 5;
  localparam int unsigned CordicSteps = 16;
  localparam int unsigned DivSteps    = 17;

  localparam logic [15:0] RstPeriod     = 16'd8000;
  localparam logic [9:0]  RstMinSpacing = 10'd80;
  localparam logic [15:0] RstMinPeriod  = 16'd6000;
  localparam logic [15:0] RstMaxPeriod  = 16'd10400;
  localparam logic [15:0] RstOffset     = 16'd0;
  localparam logic [15:0] RstAlpha      = 16'd11796;
  localparam logic [3:0]  RstAvgSamples = 4'd4;
  localparam logic [3:0]  RstMinValid   = 4'd2;

  localparam logic signed [31:0] CordicStart = 32'sd19896;
  localparam logic signed [23:0] HalfTurnZ   = 24'sd524288;
  localparam logic signed [19:0] SumLimit    = 20'sd262143;

  typedef struct packed {
    ept_op_e             op;
    logic [IterBits-1:0] iter;
  } ept_cmd_t;

  typedef struct packed {
    ept_req_e req;
    logic     spacing_ok;
    logic     qual_ok;
    logic     keep;
    logic     enough;
    logic     ema_ready;
    logic     seed_full;
  } ept_status_t;

  // arctangent of 2^-i, units of 2^-20 turn
  function automatic logic [17:0] ept_atan(input logic [3:0] i);
    logic [17:0] r;
    unique case (i)
      4'd0:  r = 18'd131072;
      4'd1:  r = 18'd77376;
      4'd2:  r = 18'd40884;
      4'd3:  r = 18'd20753;
      4'd4:  r = 18'd10417;
      4'd5:  r = 18'd5213;
      4'd6:  r = 18'd2607;
      4'd7:  r = 18'd1304;
      4'd8:  r = 18'd652;
      4'd9:  r = 18'd326;
      4'd10: r = 18'd163;
      4'd11: r = 18'd81;
      4'd12: r = 18'd41;
      4'd13: r = 18'd20;
      4'd14: r = 18'd10;
      default: r = 18'd5;
    endcase
    return r;
  endfunction

  function automatic logic signed [15:0] ept_sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sd32767;
    end else if (v < -32'sd32767) begin
      r = -16'sd32767;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [18:0] ept_sat19(input logic signed [19:0] v);
    logic signed [18:0] r;
    if (v > SumLimit) begin
      r = SumLimit[18:0];
    end else if (v < -SumLimit) begin
      r = 19'(-SumLimit);
    end else begin
      r = v[18:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/ept_in_if.sv
interface ept_in_if #(
  parameter int unsigned TICK_BITS = 48
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           req_type;
  logic [TICK_BITS-1:0] timestamp;

  modport source (output valid, output req_type, output timestamp, input ready);
  modport sink   (input valid, input req_type, input timestamp, output ready);
endinterface

### hw/rtl/ept_out_if.sv
interface ept_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] phase_angle;
  logic              fresh;
  logic              tracking;
  logic [3:0]        valid_count;

  modport source (output valid, output phase_angle, output fresh, output tracking,
                  output valid_count, input ready);
  modport sink   (input valid, input phase_angle, input fresh, input tracking,
                  input valid_count, output ready);
endinterface

### hw/rtl/ept_datapath.sv
module ept_datapath import ept_pkg::*; #(
  parameter int unsigned TICK_BITS    = 48,
  parameter int unsigned SEED_WINDOWS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i,
  input  logic [1:0]             req_type_i,
  input  logic [TICK_BITS-1:0]   timestamp_i,
  input  ept_cmd_t               cmd_i,
  output ept_status_t            status_o,
  output logic signed [15:0]     phase_angle_o,
  output logic                   fresh_o,
  output logic                   tracking_o,
  output logic [3:0]             valid_count_o
);

  // configuration
  logic [15:0] period_q, min_period_q, max_period_q, offset_q, alpha_q;
  logic [9:0]  min_spacing_q;
  logic [3:0]  avg_samples_q, min_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q      <= RstPeriod;
      min_spacing_q <= RstMinSpacing;
      min_period_q  <= RstMinPeriod;
      max_period_q  <= RstMaxPeriod;
      offset_q      <= RstOffset;
      alpha_q       <= RstAlpha;
      avg_samples_q <= RstAvgSamples;
      min_valid_q   <= RstMinValid;
    end else if (cfg_we_i) begin
      unique case (ept_cfg_e'(cfg_idx_i))
        CFG_PERIOD:      period_q      <= cfg_wdata_i;
        CFG_MIN_SPACING: min_spacing_q <= cfg_wdata_i[9:0];
        CFG_MIN_PERIOD:  min_period_q  <= cfg_wdata_i;
        CFG_MAX_PERIOD:  max_period_q  <= cfg_wdata_i;
        CFG_OFFSET:      offset_q      <= cfg_wdata_i;
        CFG_ALPHA:       alpha_q       <= cfg_wdata_i;
        CFG_AVG_SAMPLES: avg_samples_q <= cfg_wdata_i[3:0];
        CFG_MIN_VALID:   min_valid_q   <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // tracking state
  logic [TICK_BITS-1:0] ref_tick_q, ref_tick_d, last_rx_q, last_rx_d;
  logic                 ref_seen_q, ref_seen_d, ema_ready_q, ema_ready_d;
  logic signed [18:0]   sin_sum_q, sin_sum_d, cos_sum_q, cos_sum_d;
  logic signed [18:0]   seed_sin_q, seed_sin_d, seed_cos_q, seed_cos_d;
  logic [3:0]           win_cnt_q, win_cnt_d, seed_cnt_q, seed_cnt_d;
  logic signed [15:0]   ema_q, ema_d, held_q, held_d;
  logic                 fresh_q, fresh_d;

  // working registers
  logic [1:0]           req_q, req_d;
  logic [TICK_BITS-1:0] now_q, now_d, d_rx_q, d_rx_d, d_tx_q, d_tx_d;
  logic [15:0]          norm_q, norm_d, rem_q, rem_d;
  logic [16:0]          qb_q, qb_d;
  logic signed [15:0]   ang_q, ang_d, cur_q, cur_d;
  logic signed [31:0]   x_q, x_d, y_q, y_d;
  logic signed [23:0]   z_q, z_d;
  logic                 rot_q, rot_d, neg_q, neg_d, zero_q, zero_d;

  // output register
  logic signed [15:0] o_phase_q, o_phase_d;
  logic               o_fresh_q, o_fresh_d, o_track_q, o_track_d;
  logic [3:0]         o_cnt_q, o_cnt_d;

  // status
  logic [3:0]         cap;
  logic signed [15:0] ang_diff;

  assign cap      = (avg_samples_q > 4'd8) ? 4'd8 : avg_samples_q;
  assign ang_diff = ang_q - ema_q;

  always_comb begin
    status_o.req        = ept_req_e'(req_q);
    status_o.spacing_ok = d_rx_q >= TICK_BITS'(min_spacing_q);
    status_o.qual_ok    = ref_seen_q && (period_q != 16'd0) &&
                          (d_tx_q <= TICK_BITS'({period_q, 1'b0})) &&
                          (d_rx_q >= TICK_BITS'(min_period_q)) &&
                          (d_rx_q <= TICK_BITS'(max_period_q)) &&
                          (win_cnt_q < cap);
    status_o.keep       = !ema_ready_q ||
                          ((ang_diff <= 16'sd16384) && (ang_diff >= -16'sd16384));
    status_o.enough     = win_cnt_q >= min_valid_q;
    status_o.ema_ready  = ema_ready_q;
    status_o.seed_full  = seed_cnt_q >= 4'(SEED_WINDOWS);
  end

  // helpers
  logic [17:0]        d18, p18;
  logic [32:0]        num;
  logic [16:0]        div_t;
  logic               div_ge;
  logic signed [16:0] a17, a_src;
  logic signed [19:0] vx, vy, nx, ny;
  logic [3:0]         sh;
  logic signed [31:0] dx, dy;
  logic signed [23:0] at, zr;
  logic               sigma;
  logic signed [15:0] rs, rc, vres;
  logic signed [15:0] ema_diff;
  logic signed [33:0] prod;

  assign d18 = d_tx_q[17:0];
  assign p18 = {2'b00, period_q};
  assign num = {1'b0, norm_q, 16'd0} + {18'd0, period_q[15:1]};
  assign div_t  = {rem_q, qb_q[16]};
  assign div_ge = div_t >= {1'b0, period_q};

  assign sh    = cmd_i.iter[3:0];
  assign dx    = y_q >>> sh;
  assign dy    = x_q >>> sh;
  assign at    = {6'd0, ept_atan(sh)};
  assign sigma = rot_q ? !z_q[23] : (y_q <= 32'sd0);

  assign rs = neg_q ? -ept_sat16(y_q) : ept_sat16(y_q);
  assign rc = neg_q ? -ept_sat16(x_q) : ept_sat16(x_q);
  assign zr   = z_q + 24'sd8;
  assign vres = zero_q ? 16'sd0 : zr[19:4];

  assign ema_diff = cur_q - ema_q;
  assign prod     = 34'($signed({1'b0, alpha_q}) * ema_diff) + 34'sd32768;

  always_comb begin
    ref_tick_d  = ref_tick_q;  last_rx_d  = last_rx_q;
    ref_seen_d  = ref_seen_q;  ema_ready_d = ema_ready_q;
    sin_sum_d   = sin_sum_q;   cos_sum_d  = cos_sum_q;
    seed_sin_d  = seed_sin_q;  seed_cos_d = seed_cos_q;
    win_cnt_d   = win_cnt_q;   seed_cnt_d = seed_cnt_q;
    ema_d       = ema_q;       held_d     = held_q;
    fresh_d     = fresh_q;
    req_d  = req_q;  now_d  = now_q;  d_rx_d = d_rx_q; d_tx_d = d_tx_q;
    norm_d = norm_q; rem_d  = rem_q;  qb_d   = qb_q;
    ang_d  = ang_q;  cur_d  = cur_q;
    x_d = x_q; y_d = y_q; z_d = z_q; rot_d = rot_q; neg_d = neg_q; zero_d = zero_q;
    o_phase_d = o_phase_q; o_fresh_d = o_fresh_q; o_track_d = o_track_q; o_cnt_d = o_cnt_q;
    a17 = '0; a_src = '0; vx = '0; vy = '0; nx = '0; ny = '0;

    unique case (cmd_i.op)
      OP_LOAD: begin
        req_d   = req_type_i;
        now_d   = timestamp_i;
        fresh_d = 1'b0;
      end
      OP_REF: begin
        ref_tick_d = now_q;
        ref_seen_d = 1'b1;
      end
      OP_RESTART: begin
        ref_tick_d = '0; last_rx_d = '0; ref_seen_d = 1'b0; ema_ready_d = 1'b0;
        sin_sum_d = '0; cos_sum_d = '0; seed_sin_d = '0; seed_cos_d = '0;
        win_cnt_d = '0; seed_cnt_d = '0; ema_d = '0; held_d = '0;
      end
      OP_DIFF: begin
        d_rx_d = now_q - last_rx_q;
        d_tx_d = now_q - ref_tick_q;
      end
      OP_QUAL: begin
        if (status_o.spacing_ok) begin
          last_rx_d = now_q;
        end
        // lag is at most two periods here, so folding takes two compares
        if (d18 >= {p18[16:0], 1'b0}) begin
          norm_d = 16'(d18 - {p18[16:0], 1'b0});
        end else if (d18 >= p18) begin
          norm_d = 16'(d18 - p18);
        end else begin
          norm_d = d18[15:0];
        end
      end
      OP_DIV_INIT: begin
        rem_d = num[32:17];
        qb_d  = num[16:0];
      end
      OP_DIV_STEP: begin
        rem_d = div_ge ? 16'(div_t - {1'b0, period_q}) : div_t[15:0];
        qb_d  = {qb_q[15:0], div_ge};
      end
      OP_ANGLE: begin
        ang_d = qb_q[15:0] - offset_q;
      end
      OP_ROT_EDGE, OP_ROT_CUR: begin
        a_src = (cmd_i.op == OP_ROT_EDGE) ? 17'(ang_q) : 17'(cur_q);
        neg_d = 1'b1;
        if (a_src > 17'sd16384) begin
          a17 = a_src - 17'sd32768;
        end else if (a_src < -17'sd16384) begin
          a17 = a_src + 17'sd32768;
        end else begin
          a17   = a_src;
          neg_d = 1'b0;
        end
        rot_d = 1'b1;
        x_d   = CordicStart;
        y_d   = '0;
        z_d   = {{3{a17[16]}}, a17, 4'd0};
      end
      OP_VEC_WIN, OP_VEC_SEED: begin
        vx = (cmd_i.op == OP_VEC_WIN) ? 20'(cos_sum_q) : 20'(seed_cos_q);
        vy = (cmd_i.op == OP_VEC_WIN) ? 20'(sin_sum_q) : 20'(seed_sin_q);
        rot_d  = 1'b0;
        zero_d = (vx == 20'sd0) && (vy == 20'sd0);
        if (vx < 20'sd0) begin
          nx  = -vx;
          ny  = -vy;
          z_d = HalfTurnZ;
        end else begin
          nx  = vx;
          ny  = vy;
          z_d = '0;
        end
        x_d = {{4{nx[19]}}, nx, 8'd0};
        y_d = {{4{ny[19]}}, ny, 8'd0};
      end
      OP_CSTEP: begin
        x_d = sigma ? x_q - dx : x_q + dx;
        y_d = sigma ? y_q + dy : y_q - dy;
        z_d = sigma ? z_q - at : z_q + at;
      end
      OP_ACC_EDGE: begin
        sin_sum_d = sin_sum_q + 19'(rs);
        cos_sum_d = cos_sum_q + 19'(rc);
        win_cnt_d = win_cnt_q + 4'd1;
      end
      OP_CUR: begin
        cur_d = vres;
      end
      OP_SEED_ACC: begin
        seed_sin_d = ept_sat19(20'(seed_sin_q) + 20'(rs));
        seed_cos_d = ept_sat19(20'(seed_cos_q) + 20'(rc));
        seed_cnt_d = seed_cnt_q + 4'd1;
      end
      OP_SEED_FIN: begin
        ema_d       = vres;
        ema_ready_d = 1'b1;
        seed_cnt_d  = '0;
        seed_sin_d  = '0;
        seed_cos_d  = '0;
      end
      OP_EMA: begin
        ema_d   = ema_q + prod[31:16];
        held_d  = ema_q + prod[31:16];
        fresh_d = 1'b1;
      end
      OP_WIN_END: begin
        o_phase_d = held_q;
        o_fresh_d = fresh_q;
        o_track_d = ema_ready_q;
        o_cnt_d   = win_cnt_q;
        sin_sum_d = '0;
        cos_sum_d = '0;
        win_cnt_d = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_tick_q <= '0; last_rx_q <= '0; ref_seen_q <= 1'b0; ema_ready_q <= 1'b0;
      sin_sum_q <= '0; cos_sum_q <= '0; seed_sin_q <= '0; seed_cos_q <= '0;
      win_cnt_q <= '0; seed_cnt_q <= '0; ema_q <= '0; held_q <= '0;
      fresh_q <= 1'b0; req_q <= '0;
    end else begin
      ref_tick_q <= ref_tick_d; last_rx_q <= last_rx_d;
      ref_seen_q <= ref_seen_d; ema_ready_q <= ema_ready_d;
      sin_sum_q <= sin_sum_d; cos_sum_q <= cos_sum_d;
      seed_sin_q <= seed_sin_d; seed_cos_q <= seed_cos_d;
      win_cnt_q <= win_cnt_d; seed_cnt_q <= seed_cnt_d;
      ema_q <= ema_d; held_q <= held_d; fresh_q <= fresh_d; req_q <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q <= now_d; d_rx_q <= d_rx_d; d_tx_q <= d_tx_d;
    norm_q <= norm_d; rem_q <= rem_d; qb_q <= qb_d;
    ang_q <= ang_d; cur_q <= cur_d;
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
    rot_q <= rot_d; neg_q <= neg_d; zero_q <= zero_d;
    o_phase_q <= o_phase_d; o_fresh_q <= o_fresh_d;
    o_track_q <= o_track_d; o_cnt_q <= o_cnt_d;
  end

  assign phase_angle_o = o_phase_q;
  assign fresh_o       = o_fresh_q;
  assign tracking_o    = o_track_q;
  assign valid_count_o = o_cnt_q;

endmodule

### hw/rtl/ept_ctrl.sv
module ept_ctrl import ept_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  ept_status_t status_i,
  output ept_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_QUAL, ST_DIVINIT, ST_DIV, ST_ANGLE, ST_ROTE,
    ST_CSTEP, ST_ACC, ST_CUR, ST_ROTC, ST_SEEDACC, ST_SEEDCHK, ST_SEEDFIN,
    ST_EMA, ST_WINEND
  } state_e;

  state_e              state_q, state_d, ret_q, ret_d;
  logic [IterBits-1:0] iter_q, iter_d;
  logic                out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    iter_d      = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op    = OP_NOP;
    cmd_o.iter  = iter_q;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        unique case (status_i.req)
          REQ_REF: begin
            cmd_o.op = OP_REF;
            state_d  = ST_IDLE;
          end
          REQ_RESTART: begin
            cmd_o.op = OP_RESTART;
            state_d  = ST_IDLE;
          end
          REQ_RX: begin
            cmd_o.op = OP_DIFF;
            state_d  = ST_QUAL;
          end
          default: begin
            if (status_i.enough) begin
              cmd_o.op = OP_VEC_WIN;
              ret_d    = ST_CUR;
              state_d  = ST_CSTEP;
            end else begin
              state_d = ST_WINEND;
            end
          end
        endcase
      end
      ST_QUAL: begin
        cmd_o.op = OP_QUAL;
        state_d  = (status_i.spacing_ok && status_i.qual_ok) ? ST_DIVINIT : ST_IDLE;
      end
      ST_DIVINIT: begin
        cmd_o.op = OP_DIV_INIT;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        iter_d   = iter_q + 1'b1;
        if (iter_q == IterBits'(DivSteps - 1)) begin
          iter_d  = '0;
          state_d = ST_ANGLE;
        end
      end
      ST_ANGLE: begin
        cmd_o.op = OP_ANGLE;
        state_d  = ST_ROTE;
      end
      ST_ROTE: begin
        if (status_i.keep) begin
          cmd_o.op = OP_ROT_EDGE;
          ret_d    = ST_ACC;
          state_d  = ST_CSTEP;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CSTEP: begin
        cmd_o.op = OP_CSTEP;
        iter_d   = iter_q + 1'b1;
        if (iter_q == IterBits'(CordicSteps - 1)) begin
          iter_d  = '0;
          state_d = ret_q;
        end
      end
      ST_ACC: begin
        cmd_o.op = OP_ACC_EDGE;
        state_d  = ST_IDLE;
      end
      ST_CUR: begin
        cmd_o.op = OP_CUR;
        state_d  = status_i.ema_ready ? ST_EMA : ST_ROTC;
      end
      ST_ROTC: begin
        cmd_o.op = OP_ROT_CUR;
        ret_d    = ST_SEEDACC;
        state_d  = ST_CSTEP;
      end
      ST_SEEDACC: begin
        cmd_o.op = OP_SEED_ACC;
        state_d  = ST_SEEDCHK;
      end
      ST_SEEDCHK: begin
        if (status_i.seed_full) begin
          cmd_o.op = OP_VEC_SEED;
          ret_d    = ST_SEEDFIN;
          state_d  = ST_CSTEP;
        end else begin
          state_d = ST_WINEND;
        end
      end
      ST_SEEDFIN: begin
        cmd_o.op = OP_SEED_FIN;
        state_d  = ST_WINEND;
      end
      ST_EMA: begin
        cmd_o.op = OP_EMA;
        state_d  = ST_WINEND;
      end
      ST_WINEND: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_WIN_END;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hw/rtl/edge_phase_tracker.sv
// Channel   Dir  Payload                                      Transfer
// in_if     in   req_type, timestamp                          valid & ready
// out_if    out  phase_angle, fresh, tracking, valid_count    valid & ready
// cfg       in   cfg_idx_i, cfg_wdata_i                       cfg_we_i
//
// One item at a time. Reference edge and restart: load, then dispatch. Receive edge:
// if it qualifies, a 17-step restoring divider, then one 16-step CORDIC rotation.
// Window end: the shared 16-step CORDIC runs up to three times.
// The result sits in an output register; a window end waits only if it is still full.
// Reset clears all tracking state and loads the register defaults.
module edge_phase_tracker import ept_pkg::*; #(
  parameter int unsigned TICK_BITS    = 48,
  parameter int unsigned SEED_WINDOWS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  ept_in_if.sink                 in_if,
  ept_out_if.source              out_if,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [CfgDataBits-1:0] cfg_wdata_i
);

  ept_cmd_t    cmd;
  ept_status_t status;

  ept_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  ept_datapath #(
    .TICK_BITS    (TICK_BITS),
    .SEED_WINDOWS (SEED_WINDOWS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_type_i    (in_if.req_type),
    .timestamp_i   (in_if.timestamp),
    .cmd_i         (cmd),
    .status_o      (status),
    .phase_angle_o (out_if.phase_angle),
    .fresh_o       (out_if.fresh),
    .tracking_o    (out_if.tracking),
    .valid_count_o (out_if.valid_count)
  );

  a_fresh_tracking: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (!out_if.fresh || out_if.tracking))
    else $error("fresh result without tracking");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.valid_count <= 4'd8))
    else $error("window count above eight");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("input ready right after a transfer");

endmodule

### tb/sv/ept_tb_scoreboard.sv
`timescale 1ns / 100ps

class ept_phase_scoreboard;
  typedef struct {
    logic signed [15:0] phase;
    logic               fresh;
    logic               tracking;
    logic [3:0]         count;
  } window_result_t;

  // register copy
  int unsigned tx_period, min_spacing, min_period, max_period;
  int          cal_offset;
  int unsigned ema_alpha, avg_samples, min_valid;

  // tracker state
  longint unsigned ref_tick, last_rx_tick;
  bit              ref_seen, ema_ready;
  int              sin_sum, cos_sum, seed_sin, seed_cos;
  int unsigned     window_count, seed_count;
  int              ema_angle, held_angle;

  window_result_t pending_windows[$];
  int             mismatches;

  function new();
    tx_period = 8000; min_spacing = 80; min_period = 6000; max_period = 10400;
    cal_offset = 0; ema_alpha = 11796; avg_samples = 4; min_valid = 2;
    mismatches = 0;
    clear_tracking();
  endfunction

  function void clear_tracking();
    ref_tick = 0; last_rx_tick = 0; ref_seen = 0; ema_ready = 0;
    sin_sum = 0; cos_sum = 0; seed_sin = 0; seed_cos = 0;
    window_count = 0; seed_count = 0; ema_angle = 0; held_angle = 0;
  endfunction

  function void write_reg(ept_pkg::ept_cfg_e idx, logic [15:0] v);
    case (idx)
      ept_pkg::CFG_PERIOD:      tx_period = 32'(v);
      ept_pkg::CFG_MIN_SPACING: min_spacing = 32'(v[9:0]);
      ept_pkg::CFG_MIN_PERIOD:  min_period = 32'(v);
      ept_pkg::CFG_MAX_PERIOD:  max_period = 32'(v);
      ept_pkg::CFG_OFFSET:      cal_offset = 32'($signed(v));
      ept_pkg::CFG_ALPHA:       ema_alpha = 32'(v);
      ept_pkg::CFG_AVG_SAMPLES: avg_samples = 32'(v[3:0]);
      default:                  min_valid = 32'(v[3:0]);
    endcase
  endfunction

  static function int asr(int v, int s);
    return v >>> s;
  endfunction

  static function int fold16(int v);
    logic signed [15:0] t;
    t = v[15:0];
    return 32'(t);
  endfunction

  static function int turn_step(int i);
    int steps[16] = '{131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
                      652, 326, 163, 81, 41, 20, 10, 5};
    return steps[i];
  endfunction

  static function void rotate(int a, output int s, output int c);
    bit flip;
    int x, y, z, dx, dy;
    flip = 0; x = 19896; y = 0;
    if (a > 16384) begin
      a -= 32768; flip = 1;
    end else if (a < -16384) begin
      a += 32768; flip = 1;
    end
    z = a * 16;
    for (int i = 0; i < 16; i++) begin
      dx = asr(y, i); dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= turn_step(i);
      end else begin
        x += dx; y -= dy; z += turn_step(i);
      end
    end
    if (x > 32767) x = 32767;
    if (x < -32767) x = -32767;
    if (y > 32767) y = 32767;
    if (y < -32767) y = -32767;
    if (flip) begin
      x = -x; y = -y;
    end
    s = y; c = x;
  endfunction

  static function int vector_angle(int y, int x);
    int z, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      x = -x; y = -y; z = 524288;
    end
    x *= 256; y *= 256;
    for (int i = 0; i < 16; i++) begin
      dx = asr(y, i); dy = asr(x, i);
      if (y > 0) begin
        x += dx; y -= dy; z += turn_step(i);
      end else begin
        x -= dx; y += dy; z -= turn_step(i);
      end
    end
    return fold16(asr(z + 8, 4));
  endfunction

  static function int clamp_sum(int v);
    if (v > 262143) return 262143;
    if (v < -262143) return -262143;
    return v;
  endfunction

  function void rx_edge(longint unsigned now);
    longint unsigned d_rx, d_tx, norm, raw;
    int unsigned cap;
    int ang, s, c;
    bit keep;
    d_rx = (now - last_rx_tick) & 48'hFFFF_FFFF_FFFF;
    cap = avg_samples > 8 ? 8 : avg_samples;
    if (d_rx < min_spacing) return;
    if (ref_seen && tx_period != 0) begin
      d_tx = (now - ref_tick) & 48'hFFFF_FFFF_FFFF;
      if (d_tx <= 2 * longint'(tx_period) && d_rx >= min_period &&
          d_rx <= max_period && window_count < cap) begin
        norm = d_tx % tx_period;
        raw = (norm * 65536 + tx_period / 2) / tx_period;
        ang = fold16(int'(raw & 16'hFFFF) - cal_offset);
        keep = 1;
        if (ema_ready && (fold16(ang - ema_angle) > 16384 ||
                          fold16(ang - ema_angle) < -16384))
          keep = 0;
        if (keep) begin
          rotate(ang, s, c);
          sin_sum += s; cos_sum += c; window_count++;
        end
      end
    end
    last_rx_tick = now;
  endfunction

  function void close_window();
    window_result_t r;
    int cur, s, c, diff;
    longint prod, stp;
    r.count = 4'(window_count);
    r.phase = 16'(held_angle);
    r.fresh = 0;
    if (window_count >= min_valid) begin
      cur = vector_angle(sin_sum, cos_sum);
      if (!ema_ready) begin
        rotate(cur, s, c);
        seed_sin = clamp_sum(seed_sin + s);
        seed_cos = clamp_sum(seed_cos + c);
        seed_count++;
        if (seed_count >= 8) begin
          ema_angle = vector_angle(seed_sin, seed_cos);
          ema_ready = 1;
          seed_count = 0; seed_sin = 0; seed_cos = 0;
        end
      end else begin
        diff = fold16(cur - ema_angle);
        prod = longint'(ema_alpha) * diff + 32768;
        stp = prod >>> 16;
        ema_angle = fold16(ema_angle + int'(stp));
        held_angle = ema_angle;
        r.phase = 16'(ema_angle);
        r.fresh = 1;
      end
    end
    r.tracking = ema_ready;
    sin_sum = 0; cos_sum = 0; window_count = 0;
    pending_windows.push_back(r);
  endfunction

  function void note_request(ept_pkg::ept_req_e req, longint unsigned ts);
    case (req)
      ept_pkg::REQ_REF: begin
        ref_tick = ts; ref_seen = 1;
      end
      ept_pkg::REQ_RX:   rx_edge(ts);
      ept_pkg::REQ_WEND: close_window();
      default:           clear_tracking();
    endcase
  endfunction

  function void report(string what);
    $display("mismatch: %s", what);
    mismatches++;
  endfunction

  function void check_result(logic signed [15:0] phase, logic fresh, logic tracking,
                             logic [3:0] count);
    window_result_t e;
    if (pending_windows.size() == 0) begin
      report($sformatf("unexpected result phase=%0d", phase));
      return;
    end
    e = pending_windows.pop_front();
    if (phase !== e.phase) report($sformatf("phase %0d, want %0d", phase, e.phase));
    if (fresh !== e.fresh) report($sformatf("fresh %b, want %b", fresh, e.fresh));
    if (tracking !== e.tracking)
      report($sformatf("tracking %b, want %b", tracking, e.tracking));
    if (count !== e.count) report($sformatf("count %0d, want %0d", count, e.count));
  endfunction
endclass

### tb/sv/edge_phase_tracker_tb.sv
`timescale 1ns / 100ps

module edge_phase_tracker_tb;
  import ept_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  bit          sender_done = 0;

  ept_in_if  #(.TICK_BITS(48)) edge_ch ();
  ept_out_if                   window_ch ();

  ept_phase_scoreboard phase_sb = new();

  edge_phase_tracker #(.TICK_BITS(48), .SEED_WINDOWS(8)) u_top (
    .clk_i, .rst_ni, .in_if(edge_ch.sink), .out_if(window_ch.source),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    edge_ch.valid = 1'b0;
    edge_ch.req_type = '0;
    edge_ch.timestamp = '0;
    window_ch.ready = 1'b0;
  end

  longint unsigned now_tick;
  int              gap_max = 16;

  // valid stays high into the next item when no gap is drawn
  task automatic send_req(ept_req_e req, longint unsigned ts);
    int gap;
    gap = $urandom_range(gap_max);
    @(negedge clk_i);
    if (gap != 0) begin
      edge_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    edge_ch.valid <= 1'b1;
    edge_ch.req_type <= req;
    edge_ch.timestamp <= ts[47:0];
    do @(posedge clk_i); while (!edge_ch.ready);
    phase_sb.note_request(req, ts[47:0]);
  endtask

  task automatic set_reg(ept_cfg_e idx, logic [15:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= v;
    phase_sb.write_reg(idx, v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk_i);
    edge_ch.valid <= 1'b0;
    while (phase_sb.pending_windows.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // per edge: ref edge then rx edge with jittered lag near a phase; then a window end
  task automatic run_window(int edges, int phase_turn, int jitter);
    int unsigned per, lag;
    per = phase_sb.tx_period == 0 ? 8000 : phase_sb.tx_period;
    for (int k = 0; k < edges; k++) begin
      now_tick += per;
      send_req(REQ_REF, now_tick);
      lag = ((phase_turn + $urandom_range(2 * jitter) - jitter) & 16'hFFFF) * per / 65536;
      send_req(REQ_RX, now_tick + lag);
    end
    send_req(REQ_WEND, now_tick + per / 2);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 40) send_req(REQ_RX, now_tick + $urandom_range(12000));
    else if (r < 70) begin
      now_tick += $urandom_range(20000);
      send_req(REQ_REF, now_tick);
    end else if (r < 92) send_req(REQ_WEND, now_tick);
    else if (r < 96) send_req(REQ_RESTART, now_tick);
    else send_req(REQ_RX, {$urandom, $urandom});
  endtask

  always begin
    @(negedge clk_i);
    if ($urandom_range(3) == 0) begin
      window_ch.ready <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    window_ch.ready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && window_ch.valid && window_ch.ready)
      phase_sb.check_result(window_ch.phase_angle, window_ch.fresh, window_ch.tracking,
                            window_ch.valid_count);
  end

  initial begin
    int n;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    now_tick = 48'hFFFF_FFFF_0000;

    // directed: extremes of fields and special cases
    send_req(REQ_RX, 0);
    send_req(REQ_WEND, 48'hFFFF_FFFF_FFFF);
    send_req(REQ_REF, 48'hFFFF_FFFF_FFFF);
    send_req(REQ_RX, 48'h0000_0000_1000);
    send_req(REQ_RX, 48'h0000_0000_1010);
    send_req(REQ_RX, 48'hAAAA_5555_AAAA);
    send_req(REQ_WEND, 48'h5555_AAAA_5555);
    send_req(REQ_RESTART, 48'hFFFF_FFFF_FFFF);
    send_req(REQ_WEND, 0);
    for (int w = 0; w < 11; w++) run_window(4, w * 6000, 3000);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      set_reg(CFG_PERIOD, ph == 0 ? 16'd800 : ph == 5 ? 16'd0 : 16'($urandom_range(800, 40000)));
      set_reg(CFG_MIN_SPACING, ph == 1 ? 16'd1023 : ph == 2 ? 16'd0 : 16'($urandom_range(1023)));
      set_reg(CFG_MIN_PERIOD, ph == 2 ? 16'd600 : 16'(phase_sb.tx_period * 3 / 4));
      set_reg(CFG_MAX_PERIOD, ph == 2 ? 16'd52000 : 16'(phase_sb.tx_period * 5 / 4 + 10));
      set_reg(CFG_OFFSET, ph == 0 ? 16'h8000 : ph == 1 ? 16'h7FFF : 16'($urandom));
      set_reg(CFG_ALPHA, ph == 0 ? 16'd0 : ph == 1 ? 16'hFFFF : 16'($urandom));
      set_reg(CFG_AVG_SAMPLES, ph == 3 ? 16'd0 : ph == 4 ? 16'd15 : 16'($urandom_range(1, 8)));
      set_reg(CFG_MIN_VALID, ph == 3 ? 16'd0 : 16'($urandom_range(1, 8)));
      gap_max = ph == 2 ? 0 : 16;
      n = 0;
      while (n < 225) begin
        if ($urandom_range(9) < 7) begin
          run_window($urandom_range(1, 9), $urandom, $urandom_range(1, 20000));
          n += 10;
        end else begin
          random_item();
          n++;
        end
      end
      drain();
    end
    sender_done = 1;
  end

  initial begin
    wait (sender_done);
    if (phase_sb.mismatches == 0 && phase_sb.pending_windows.size() == 0) begin
      $display("PASS edge_phase_tracker");
    end else begin
      $display("FAIL edge_phase_tracker");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL edge_phase_tracker");
    $finish;
  end
endmodule

### edge_phase_tracker.f
hw/rtl/ept_pkg.sv
hw/rtl/ept_in_if.sv
hw/rtl/ept_out_if.sv
hw/rtl/ept_datapath.sv
hw/rtl/ept_ctrl.sv
hw/rtl/edge_phase_tracker.sv
tb/sv/ept_tb_scoreboard.sv
tb/sv/edge_phase_tracker_tb.sv
